// File: hw/rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned SizeW    = 16;
  localparam int unsigned IbW      = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_BLK_BYTES     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_BLOCKS = 2'd1;

  localparam logic [SizeW-1:0] BLK_BYTES_RST     = 16'd64;
  localparam logic [IbW-1:0]   INITIAL_BLOCKS_RST = 9'd16;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SIZE_MISMATCH = 3'd1,
    ST_ZERO_SIZE     = 3'd2,
    ST_FREE_RANGE    = 3'd3,
    ST_FREE_RESERVED = 3'd4,
    ST_EXHAUSTED     = 3'd5
  } status_e;

  // What the held request needs next
  typedef enum logic [1:0] {
    DEC_IMM  = 2'd0,
    DEC_POP  = 2'd1,
    DEC_GROW = 2'd2
  } dec_e;

  typedef enum logic [2:0] {
    S_SETUP  = 3'd0,
    S_INIT   = 3'd1,
    S_IDLE   = 3'd2,
    S_DECIDE = 3'd3,
    S_GROW   = 3'd4,
    S_POP    = 3'd5
  } state_e;

  typedef struct packed {
    logic take_item;
    logic setup_init;
    logic setup_grow;
    logic walk_step;
    logic walk_done;
    logic commit_imm;
    logic issue_read;
    logic commit_pop;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_rebuild;
    dec_e dec;
    logic walk_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator.
// Fixed-size block pool allocator with a LIFO free list of next links.
// Request channel (in_valid_i / in_stall_o): action_i 0 allocates a block of
// req_size_i bytes, 1 frees free_handle_i. A request is taken when valid is
// high and stall is low. Response channel (out_valid_o / out_stall_i) gives
// status_o and alloc_handle_o, one response per request, in order.
// A free or any rejected request answers straight from the decide state; an
// allocation from the list answers after the single link memory read of the
// head block. When the list is empty and the pool may grow, the doubling
// walk that links the new blocks above the old pool size runs before the pop.
// A new request is taken only in the idle state, entered once the previous response is written.
// At reset, and after every write of initial_blocks, the list is rebuilt by a
// walk over max(1, min(initial_blocks, MAX_BLOCKS)) blocks with stall high.
// A stalled response holds in the output register; the block finishes the
// next request up to its response and then waits for the register to empty.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready: index 0 is the
// accepted block size in bytes, index 1 is initial_blocks; others are ignored.
module fixed_block_pool_allocator_core #(
  parameter  int unsigned MAX_BLOCKS = 256,
  localparam int unsigned HandleW    = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [fbpa_pkg::SizeW-1:0]     req_size_i,
  input  logic [HandleW-1:0]             free_handle_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [HandleW-1:0]             alloc_handle_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fbpa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready_o = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .req_size_i     (req_size_i),
    .free_handle_i  (free_handle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .alloc_handle_o (alloc_handle_o)
  );

endmodule

// File: hw/rtl/fbpa_ctrl.sv
// Sequencer of the pool allocator: list builds, request decode, pop and response.
module fbpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbpa_pkg::dp_status_t stat_i,
  output fbpa_pkg::dp_cmd_t    cmd_o
);
  import fbpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SETUP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SETUP:  state_d = S_INIT;
      S_INIT: begin
        if (stat_i.walk_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (stat_i.dec)
          DEC_POP:  state_d = S_POP;
          DEC_GROW: state_d = S_GROW;
          default: begin
            if (stat_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_GROW: begin
        if (stat_i.walk_last) state_d = S_DECIDE;
      end
      S_POP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_SETUP;
    endcase
    // a write of the initial count restarts the build
    if (stat_i.cfg_rebuild) state_d = S_SETUP;
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_SETUP: cmd_o.setup_init = 1'b1;
      S_INIT: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.walk_done = stat_i.walk_last;
      end
      S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take_item = in_valid_i;
      end
      S_DECIDE: begin
        unique case (stat_i.dec)
          DEC_POP:  cmd_o.issue_read = 1'b1;
          DEC_GROW: cmd_o.setup_grow = 1'b1;
          default:  cmd_o.commit_imm = stat_i.out_free;
        endcase
      end
      S_GROW: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.walk_done = stat_i.walk_last;
      end
      S_POP: cmd_o.commit_pop = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/fbpa_dp.sv
// Datapath of the pool allocator: registers, link memory, decode and response register.
module fbpa_dp #(
  parameter  int unsigned MAX_BLOCKS = 256,
  localparam int unsigned HandleW    = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbpa_pkg::dp_cmd_t              cmd_i,
  output fbpa_pkg::dp_status_t           stat_o,
  input  logic                           cfg_valid_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           action_i,
  input  logic [fbpa_pkg::SizeW-1:0]     req_size_i,
  input  logic [HandleW-1:0]             free_handle_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [HandleW-1:0]             alloc_handle_o
);
  import fbpa_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_BLOCKS);
  localparam int unsigned CmpW  = (HandleW + 1 > IbW) ? HandleW + 1 : IbW;
  localparam logic [CmpW-1:0]    MaxCmp  = CmpW'(MAX_BLOCKS);
  localparam logic [HandleW:0]   MaxGrow = (HandleW + 1)'(MAX_BLOCKS);
  localparam logic [HandleW-1:0] One     = HandleW'(1);

  logic [SizeW-1:0]   blk_bytes_q;
  logic [IbW-1:0]     init_blocks_q;
  action_e            act_q;
  logic [SizeW-1:0]   size_q;
  logic [HandleW-1:0] fh_q;
  logic [HandleW-1:0] head_q, active_q, base_q, top_q, walk_q;
  logic [HandleW-1:0] rdata_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [HandleW-1:0] out_handle_q;

  logic [HandleW-1:0] mem [MAX_BLOCKS];

  logic [CmpW-1:0]    ib_ext;
  logic [HandleW-1:0] n_clamp;
  logic [HandleW:0]   grown;
  dec_e               dec;
  status_e            imm_status;
  logic               imm_push;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr, rd_addr;
  logic [HandleW-1:0] wr_data, head_m1, fh_m1, walk_p1;
  logic               out_free;

  // configuration registers, always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_bytes_q   <= BLK_BYTES_RST;
      init_blocks_q <= INITIAL_BLOCKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLK_BYTES:      blk_bytes_q   <= cfg_data_i;
        CFG_INITIAL_BLOCKS: init_blocks_q <= cfg_data_i[IbW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the pool acts as the pool size
  assign ib_ext = CmpW'(init_blocks_q);
  always_comb begin
    if (ib_ext == '0) begin
      n_clamp = One;
    end else if (ib_ext > MaxCmp) begin
      n_clamp = HandleW'(MAX_BLOCKS);
    end else begin
      n_clamp = HandleW'(ib_ext);
    end
  end

  assign grown   = {active_q, 1'b0};
  assign head_m1 = head_q - One;
  assign fh_m1   = fh_q - One;
  assign walk_p1 = walk_q + One;

  always_comb begin
    dec        = DEC_IMM;
    imm_status = ST_OK;
    imm_push   = 1'b0;
    if (act_q == ACT_ALLOC) begin
      if (size_q == '0) begin
        imm_status = ST_ZERO_SIZE;
      end else if (size_q != blk_bytes_q) begin
        imm_status = ST_SIZE_MISMATCH;
      end else if (head_q != '0) begin
        dec = DEC_POP;
      end else if (grown > MaxGrow) begin
        imm_status = ST_EXHAUSTED;
      end else begin
        dec = DEC_GROW;
      end
    end else begin
      if (fh_q == '0) begin
        imm_status = ST_FREE_RESERVED;
      end else if (fh_q > active_q) begin
        imm_status = ST_FREE_RANGE;
      end else begin
        imm_push = 1'b1;
      end
    end
  end

  // request hold register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      act_q  <= action_e'(action_i);
      size_q <= req_size_i;
      fh_q   <= free_handle_i;
    end
  end

  // list head, pool size and build walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      active_q <= '0;
      base_q   <= '0;
      top_q    <= '0;
      walk_q   <= '0;
    end else begin
      if (cmd_i.setup_init) begin
        head_q   <= '0;
        active_q <= n_clamp;
        base_q   <= '0;
        top_q    <= n_clamp;
        walk_q   <= '0;
      end
      if (cmd_i.setup_grow) begin
        active_q <= grown[HandleW-1:0];
        base_q   <= active_q;
        top_q    <= grown[HandleW-1:0];
        walk_q   <= active_q;
      end
      if (cmd_i.walk_step) walk_q <= walk_p1;
      if (cmd_i.walk_done) head_q <= top_q;
      if (cmd_i.commit_imm && imm_push) head_q <= fh_q;
      if (cmd_i.commit_pop) head_q <= rdata_q;
    end
  end

  // block j links to handle j, the first block of a walk ends the list
  assign wr_en   = cmd_i.walk_step || (cmd_i.commit_imm && imm_push);
  assign wr_addr = cmd_i.walk_step ? walk_q[AddrW-1:0] : fh_m1[AddrW-1:0];
  assign wr_data = cmd_i.walk_step ? ((walk_q == base_q) ? '0 : walk_q) : head_q;
  assign rd_addr = head_m1[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.issue_read) rdata_q <= mem[rd_addr];
  end

  // response register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_imm || cmd_i.commit_pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_imm) begin
      out_status_q <= imm_status;
      out_handle_q <= '0;
    end else if (cmd_i.commit_pop) begin
      out_status_q <= ST_OK;
      out_handle_q <= head_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign alloc_handle_o = out_handle_q;

  assign stat_o.cfg_rebuild = cfg_valid_i && (cfg_index_i == CFG_INITIAL_BLOCKS);
  assign stat_o.dec         = dec;
  assign stat_o.walk_last   = (walk_p1 == top_q);
  assign stat_o.out_free    = out_free;

`ifndef NO_ASSERTIONS
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_imm || cmd_i.commit_pop) |-> out_free)
    else $error("response written while the output register is occupied");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_imm || cmd_i.commit_pop) |=> out_valid_q)
    else $error("response lost after commit");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= active_q)
    else $error("list head beyond the active pool");
  a_read_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_read |-> (head_q != '0))
    else $error("pop from an empty list");
  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_pop |-> ($past(cmd_i.issue_read) || $past(cmd_i.commit_pop) ||
                          $past(out_valid_q && out_stall_i)))
    else $error("pop committed without a link read");
`endif

endmodule
